FILE: rtl/fvsm_pkg.sv
// shared constants, types and controller/datapath interface for the sample mixer
`default_nettype none

package fvsm_pkg;

  localparam int VOICES       = 4;
  localparam int SAMPLE_DEPTH = 65536;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int VIDX_W       = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SUM_W        = $clog2(VOICES) + 10;
  localparam int CTR_W        = 24;
  localparam int MUL_A_W      = 24;
  localparam int MUL_B_W      = 16;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int GAIN_RESET   = 255;
  localparam int CENTER       = 128;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INC,
    ST_MUL,
    ST_CHK,
    ST_READ,
    ST_SMUL,
    ST_ACC,
    ST_MIX,
    ST_GAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              tick_start;
    logic              inc;
    logic              mul_pos;
    logic              reload;
    logic              stop;
    logic              latch_addr;
    logic              mem_read;
    logic              mul_smp;
    logic              acc;
    logic              mix;
    logic              mul_gain;
    logic              load_out;
    logic [VIDX_W-1:0] vidx;
  } cmd_t;

  typedef struct packed {
    logic over;
    logic restart_nz;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/fvsm_ctrl.sv
// sequencer that walks the voices for each tick and drives the datapath
`default_nettype none

module fvsm_ctrl
  import fvsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_accept,
  input  wire logic [1:0] in_action,
  input  wire status_t    st,
  output logic            in_ready,
  output cmd_t            cmd
);

  state_t            state_r, state_nxt;
  logic [VIDX_W-1:0] vidx_r, vidx_nxt;
  logic              retry_r, retry_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vidx_r  <= '0;
      retry_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vidx_r  <= vidx_nxt;
      retry_r <= retry_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    vidx_nxt  = vidx_r;
    retry_nxt = retry_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.vidx  = vidx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_accept && in_action == ACT_TICK) begin
          cmd.tick_start = 1'b1;
          vidx_nxt       = '0;
          state_nxt      = ST_INC;
        end
      end
      ST_INC: begin
        cmd.inc   = 1'b1;
        retry_nxt = 1'b0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_pos = 1'b1;
        state_nxt   = ST_CHK;
      end
      ST_CHK: begin
        if (!retry_r && st.over && st.restart_nz) begin
          cmd.reload = 1'b1;
          retry_nxt  = 1'b1;
          state_nxt  = ST_MUL;
        end else begin
          cmd.stop       = !retry_r && st.over;
          cmd.latch_addr = 1'b1;
          state_nxt      = ST_READ;
        end
      end
      ST_READ: begin
        cmd.mem_read = 1'b1;
        state_nxt    = ST_SMUL;
      end
      ST_SMUL: begin
        cmd.mul_smp = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (vidx_r == VIDX_W'(VOICES - 1)) begin
          state_nxt = ST_MIX;
        end else begin
          vidx_nxt  = vidx_r + 1'b1;
          state_nxt = ST_INC;
        end
      end
      ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.mul_gain = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (!st.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/fvsm_dp.sv
// voice registers, sample memory, shared multiplier, mix accumulator and output register
`default_nettype none

module fvsm_dp
  import fvsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_accept,
  input  wire logic [1:0]  in_action,
  input  wire logic [1:0]  in_voice,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_sample_byte,
  input  wire logic [15:0] in_length,
  input  wire logic [15:0] in_speed,
  input  wire logic [23:0] in_restart_point,
  input  wire logic [7:0]  in_volume,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire cmd_t        cmd,
  output status_t          st,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [7:0]       out_level,
  output logic [3:0]       out_playing_mask
);

  logic [CTR_W-1:0]   ctr_r   [VOICES];
  logic [15:0]        base_r  [VOICES];
  logic [15:0]        len_r   [VOICES];
  logic [15:0]        spd_r   [VOICES];
  logic [CTR_W-1:0]   rstp_r  [VOICES];
  logic [7:0]         vol_r   [VOICES];
  logic [VOICES-1:0]  playing_r;
  logic [7:0]         gain_r;

  logic [7:0]         mem [SAMPLE_DEPTH];
  logic [ADDR_W-1:0]  addr_r;
  logic [7:0]         smp_r;
  logic               neg_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_r;

  logic signed [SUM_W-1:0] sum_r;
  logic [7:0]              mix_r;
  logic                    out_valid_r;
  logic [7:0]              level_r;
  logic [3:0]              mask_r;

  logic [31:0]        vext;
  logic               voice_ok;
  logic [VIDX_W-1:0]  vsel;
  logic [31:0]        wext;
  logic [31:0]        pos;
  logic [31:0]        rd_sum;
  logic [7:0]         mag;
  logic [16:0]        round_up;
  logic signed [9:0]  val;
  logic signed [SUM_W-1:0] quart;
  logic signed [SUM_W-1:0] mix_wide;
  logic [7:0]         mix_clamp;
  logic [7:0]         pl8;
  logic               do_start;
  logic               do_write;

  assign vext     = 32'(in_voice);
  assign voice_ok = vext < VOICES;
  assign vsel     = vext[VIDX_W-1:0];
  assign wext     = 32'(in_address);
  assign do_start = in_accept && in_action == ACT_START && voice_ok;
  assign do_write = in_accept && in_action == ACT_WRITE;

  assign pos    = mul_r[39:8];
  assign rd_sum = 32'(base_r[cmd.vidx]) + pos;

  assign st.over       = pos >= 32'(len_r[cmd.vidx]);
  assign st.restart_nz = rstp_r[cmd.vidx] != '0;
  assign st.out_busy   = out_valid_r && !out_ready;

  // voice state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        ctr_r[i]  <= '0;
        base_r[i] <= '0;
        len_r[i]  <= '0;
        spd_r[i]  <= '0;
        rstp_r[i] <= '0;
        vol_r[i]  <= '0;
      end
      playing_r <= '0;
      gain_r    <= 8'(GAIN_RESET);
    end else begin
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      if (do_start) begin
        base_r[vsel]    <= in_address;
        len_r[vsel]     <= in_length;
        spd_r[vsel]     <= in_speed;
        rstp_r[vsel]    <= in_restart_point;
        vol_r[vsel]     <= in_volume;
        ctr_r[vsel]     <= '0;
        playing_r[vsel] <= 1'b1;
      end
      if (cmd.inc) begin
        ctr_r[cmd.vidx] <= ctr_r[cmd.vidx] + 1'b1;
      end
      if (cmd.reload) begin
        ctr_r[cmd.vidx] <= rstp_r[cmd.vidx];
      end
      if (cmd.stop) begin
        ctr_r[cmd.vidx]     <= '0;
        playing_r[cmd.vidx] <= 1'b0;
      end
    end
  end

  // sample memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wext[ADDR_W-1:0]] <= in_sample_byte;
    end
    if (cmd.mem_read) begin
      smp_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_addr) begin
      addr_r <= rd_sum[ADDR_W-1:0];
    end
    if (cmd.mul_smp) begin
      neg_r <= smp_r < 8'(CENTER);
    end
  end

  assign mag = (smp_r >= 8'(CENTER)) ? smp_r - 8'(CENTER) : 8'(CENTER) - smp_r;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (1'b1)
      cmd.mul_pos: begin
        mul_a = ctr_r[cmd.vidx];
        mul_b = spd_r[cmd.vidx];
      end
      cmd.mul_smp: begin
        mul_a = MUL_A_W'(mag);
        mul_b = MUL_B_W'(vol_r[cmd.vidx]);
      end
      cmd.mul_gain: begin
        mul_a = MUL_A_W'(mix_r);
        mul_b = MUL_B_W'(gain_r);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_pos || cmd.mul_smp || cmd.mul_gain) begin
      mul_r <= mul_a * mul_b;
    end
  end

  // floor of the signed product over 256
  assign round_up = 17'(mul_r[15:0]) + 17'd255;
  assign val = neg_r ? -$signed({2'b00, round_up[15:8]}) : $signed({2'b00, mul_r[15:8]});

  // sum over 4 toward zero, recenter, clamp
  assign quart     = (sum_r >= 0) ? (sum_r >>> 2) : -((-sum_r) >>> 2);
  assign mix_wide  = quart + SUM_W'(CENTER);
  assign mix_clamp = (mix_wide < 0) ? 8'd0 :
                     (mix_wide > SUM_W'(255)) ? 8'd255 : mix_wide[7:0];

  assign pl8 = 8'(playing_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        sum_r <= '0;
      end
      if (cmd.acc && playing_r[cmd.vidx]) begin
        sum_r <= sum_r + SUM_W'(val);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      mix_r <= mix_clamp;
    end
    if (cmd.load_out) begin
      level_r <= mul_r[15:8];
      mask_r  <= pl8[3:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_level        = level_r;
  assign out_playing_mask = mask_r;

  a_start_plays: assert property (@(posedge clk) disable iff (!rst_n)
    do_start |=> playing_r[$past(vsel)])
    else $error("started voice not playing");

  a_tick_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_start |=> sum_r == '0)
    else $error("mix sum not cleared at tick");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_out))
    else $error("result word without load");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result word overwritten while stalled");

endmodule

`default_nettype wire

FILE: rtl/four_voice_sample_mixer.sv
// top level of the four-voice sample playback mixer
`default_nettype none

// Four voices play unsigned 8-bit samples from a shared 64 KiB sample memory.
// An input word with tuser = 2 writes one memory byte and one with tuser = 1
// starts a voice; both complete in the cycle they are accepted. A word with
// tuser = 0 is a tick: the voices are stepped one after another through one
// shared 24x16 multiplier and the single memory read port (position, length
// check, a recomputed position when a voice reaches its end and reloads a
// nonzero restart point, sample read, volume, accumulate), followed by the
// mix, the master gain and the output register. A new word is accepted once
// the previous tick has been handed to the output register; the output word
// then waits there for out_tready without blocking the input. cfg_wr_en
// writes master_gain, which resets to 255.

module four_voice_sample_mixer
  import fvsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // voice[1:0], address[17:2], sample_byte[25:18], length[41:26],
  // speed[57:42], restart_point[81:58], volume[89:82], zero pad
  input  wire logic [95:0] in_tdata,
  // action[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // level[7:0], playing_mask[11:8], zero pad
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  cmd_t       cmd;
  status_t    st;
  logic       in_ready;
  logic       in_accept;
  logic [7:0] level;
  logic [3:0] mask;

  assign in_tready = in_ready;
  assign in_accept = in_tvalid && in_ready;

  fvsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_action (in_tuser),
    .st        (st),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  fvsm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_accept        (in_accept),
    .in_action        (in_tuser),
    .in_voice         (in_tdata[1:0]),
    .in_address       (in_tdata[17:2]),
    .in_sample_byte   (in_tdata[25:18]),
    .in_length        (in_tdata[41:26]),
    .in_speed         (in_tdata[57:42]),
    .in_restart_point (in_tdata[81:58]),
    .in_volume        (in_tdata[89:82]),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .cmd              (cmd),
    .st               (st),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .out_level        (level),
    .out_playing_mask (mask)
  );

  assign out_tdata = {4'b0000, mask, level};

endmodule

`default_nettype wire
